### rtl/averaged_sensor_hysteresis_thermostat_core_assert.svh
// Assertion macros used by the thermostat top level
`ifndef AVERAGED_SENSOR_HYSTERESIS_THERMOSTAT_CORE_ASSERT_SVH
`define AVERAGED_SENSOR_HYSTERESIS_THERMOSTAT_CORE_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define ASHTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while in reset
`define ASHTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/ashtc_pkg.sv
// Shared constants, types and command struct for the thermostat core
`default_nettype none
package ashtc_pkg;

  localparam int SAMPLE_COUNT_DEFAULT = 10;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 16;
  localparam int AVG_W    = 10;
  localparam int TEMP_W   = 16;
  localparam int THR_W    = 8;
  localparam int CFG_IDX_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD = 8'd1;

  localparam logic [THR_W-1:0] ON_THRESHOLD_RESET  = 8'd70;
  localparam logic [THR_W-1:0] OFF_THRESHOLD_RESET = 8'd75;

  // curve coefficients scaled by 2^24
  localparam logic [12:0] COEF2 = 13'd4362;
  localparam logic [21:0] COEF1 = 22'd3605424;
  localparam logic [30:0] COEF0 = 31'd1230679258;

  localparam int SQ_W   = 2 * AVG_W;
  localparam int C2SQ_W = 13 + SQ_W;
  localparam int C1A_W  = 22 + AVG_W;
  localparam int V_W    = 36;
  localparam int Q_W    = V_W - 16;

  typedef struct packed {
    logic take_sample;
    logic batch_end;
    logic div_step;
    logic square;
    logic product;
    logic accumulate;
    logic round;
    logic load_out;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

### rtl/ashtc_ctrl.sv
// Sequencer: sample counting, divide, curve stages and output handshake
`default_nettype none
module ashtc_ctrl
  import ashtc_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_stall,
  output logic      out_valid,
  output logic      busy,
  output logic      last_sample,
  output ctrl_cmd_t cmd
);

  localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQ,
    S_PROD,
    S_SUM,
    S_ROUND,
    S_OUT
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       sample_index;
  logic                   take;

  assign busy        = (state != S_IDLE);
  assign last_sample = (sample_index == LAST_IDX);
  // a batch may only close when the previous one has left the datapath
  assign in_stall    = busy && last_sample;
  assign take        = in_valid && !in_stall;

  always_comb begin
    cmd             = '0;
    cmd.take_sample = take;
    cmd.batch_end   = take && last_sample;
    cmd.div_step    = (state == S_DIV);
    cmd.square      = (state == S_SQ);
    cmd.product     = (state == S_PROD);
    cmd.accumulate  = (state == S_SUM);
    cmd.round       = (state == S_ROUND);
    cmd.load_out    = (state == S_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        sample_index <= last_sample ? '0 : sample_index + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && last_sample) begin
            state <= S_DIV;
          end
        end
        S_DIV:   state <= S_SQ;
        S_SQ:    state <= S_PROD;
        S_PROD:  state <= S_SUM;
        S_SUM:   state <= S_ROUND;
        S_ROUND: state <= S_OUT;
        S_OUT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/ashtc_dp.sv
// Datapath: accumulator, reciprocal divider, curve evaluation, thermostat, output register
`default_nettype none
module ashtc_dp
  import ashtc_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctrl_cmd_t            cmd,
  input  wire logic [SAMPLE_W-1:0]  sample,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data,
  output logic [AVG_W-1:0]          average_reading,
  output logic [TEMP_W-1:0]         temperature,
  output logic                      heater_on,
  output logic                      heater_changed,
  output logic                      heater_state
);

  // mean by reciprocal multiply: ceil(2^22 / SAMPLE_COUNT) gives the exact
  // truncated quotient for any 16-bit sum with up to 64 samples per batch
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = SUM_W + RECIP_SHIFT + 1;
  localparam logic [RECIP_SHIFT:0] RECIP =
    (RECIP_SHIFT + 1)'(((1 << RECIP_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

  logic [THR_W-1:0]   on_threshold;
  logic [THR_W-1:0]   off_threshold;
  logic [SUM_W-1:0]   sample_sum;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]   div_sum;
  logic [PROD_W-1:0]  recip_prod;
  logic [AVG_W-1:0]   quo;
  logic [SQ_W-1:0]    sq;
  logic [C2SQ_W-1:0]  c2sq;
  logic [C1A_W-1:0]   c1a;
  logic signed [V_W-1:0] v;
  logic signed [V_W-1:0] v_rnd;
  logic signed [Q_W-1:0] q;
  logic [TEMP_W-1:0]  temp_calc;
  logic [TEMP_W-1:0]  temp_clamped;
  logic               switch_heater;

  assign sum_next = SUM_W'({1'b0, sample_sum} + (SUM_W + 1)'(sample));

  assign recip_prod = PROD_W'(div_sum) * PROD_W'(RECIP);

  assign v_rnd = v + V_W'(32768);
  assign q     = Q_W'(v_rnd >>> 16);

  always_comb begin
    if (v < 0) begin
      temp_clamped = '0;
    end else if (|q[Q_W-1:TEMP_W]) begin
      temp_clamped = '1;
    end else begin
      temp_clamped = q[TEMP_W-1:0];
    end
  end

  always_comb begin
    if (!heater_state) begin
      switch_heater = (temp_calc < {on_threshold, 8'h00});
    end else begin
      switch_heater = (temp_calc > {off_threshold, 8'h00});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold  <= ON_THRESHOLD_RESET;
      off_threshold <= OFF_THRESHOLD_RESET;
      sample_sum    <= '0;
      heater_state  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ON_THRESHOLD:  on_threshold  <= cfg_data;
          REG_OFF_THRESHOLD: off_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.batch_end) begin
        sample_sum <= '0;
      end else if (cmd.take_sample) begin
        sample_sum <= sum_next;
      end
      if (cmd.load_out) begin
        heater_state <= heater_state ^ switch_heater;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.batch_end) begin
      div_sum <= sum_next;
    end
    if (cmd.div_step) begin
      quo <= recip_prod[RECIP_SHIFT +: AVG_W];
    end
    if (cmd.square) begin
      sq <= SQ_W'(quo) * SQ_W'(quo);
    end
    if (cmd.product) begin
      c2sq <= C2SQ_W'(COEF2) * C2SQ_W'(sq);
      c1a  <= C1A_W'(COEF1) * C1A_W'(quo);
    end
    if (cmd.accumulate) begin
      v <= $signed(V_W'(c2sq)) - $signed(V_W'(c1a)) + $signed(V_W'(COEF0));
    end
    if (cmd.round) begin
      temp_calc <= temp_clamped;
    end
    if (cmd.load_out) begin
      average_reading <= quo;
      temperature     <= temp_calc;
      heater_on       <= heater_state ^ switch_heater;
      heater_changed  <= switch_heater;
    end
  end

endmodule
`default_nettype wire

### rtl/averaged_sensor_hysteresis_thermostat_core.sv
// Averaging thermostat core: batches ADC samples, evaluates the curve, drives the heater
// Usage:
//   Input channel (in_valid/in_stall, sample): one 10-bit reading per item,
//   taken at any rate up to one per cycle. Every SAMPLE_COUNT items close a
//   batch and produce one result; other items produce none.
//   Output channel (out_valid/out_stall): average_reading, temperature
//   (Q8.8 degrees), heater_on, heater_changed, held in an output register.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   the on threshold, 1 the off threshold; cfg_ready is always high, other
//   indexes are ignored. Write only while the core is idle.
// Flow: a batch result goes through divide by reciprocal multiply, square,
//   products, sum, rounding and output load after the item that closes it.
//   Samples of the next batch are taken meanwhile; the item that would
//   close it is stalled until the previous result sits in the output
//   register.
// A stalled output keeps its result; the next result then waits in the
//   datapath and in turn holds off the input.
// Reset clears the sum, sample count and heater (off) and restores the
//   thresholds to 70 and 75 degrees.
`default_nettype none
module averaged_sensor_hysteresis_thermostat_core
  import ashtc_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [AVG_W-1:0]          average_reading,
  output logic [TEMP_W-1:0]         temperature,
  output logic                      heater_on,
  output logic                      heater_changed,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  `include "averaged_sensor_hysteresis_thermostat_core_assert.svh"

  ctrl_cmd_t cmd;
  logic      busy;
  logic      last_sample;
  logic      heater_state;

  assign cfg_ready = 1'b1;

  ashtc_ctrl #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .busy        (busy),
    .last_sample (last_sample),
    .cmd         (cmd)
  );

  ashtc_dp #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sample          (sample),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .average_reading (average_reading),
    .temperature     (temperature),
    .heater_on       (heater_on),
    .heater_changed  (heater_changed),
    .heater_state    (heater_state)
  );

  // a batch never closes while the previous one is still being worked on
  `ASHTC_ASSERT_IMPL(a_no_batch_overrun, clk, rst, in_valid && !in_stall && last_sample, !busy)
  // the presented heater drive matches the live heater state
  `ASHTC_ASSERT_IMPL(a_heater_matches, clk, rst, out_valid, heater_on == heater_state)
  // a result is loaded only when the output register is free or being emptied
  `ASHTC_ASSERT_NEXT(a_no_result_lost, clk, rst, out_valid && out_stall, out_valid && $stable(temperature))

endmodule
`default_nettype wire

### tb/tb_averaged_sensor_hysteresis_thermostat_core.sv
// Testbench for the averaging thermostat core: directed table, random batches, scoreboard
module tb_averaged_sensor_hysteresis_thermostat_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ashtc_pkg::*;

  localparam int BATCH             = SAMPLE_COUNT_DEFAULT;
  localparam int QUIET_LIMIT       = 2000;
  localparam int HOLD_OFF_CYCLES   = 250;
  localparam int SETTLE_CYCLES     = 20;
  localparam int PHASES            = 8;
  localparam int BATCHES_PER_PHASE = 7;
  localparam int DIRECTED_LEN      = 25;
  localparam int PICK_RANDOM       = -1;
  localparam int SAMPLE_MAX        = (1 << SAMPLE_W) - 1;

  localparam longint K2 = longint'(COEF2);
  localparam longint K1 = longint'(COEF1);
  localparam longint K0 = longint'(COEF0);

  typedef struct packed {
    logic [AVG_W-1:0]  average;
    logic [TEMP_W-1:0] temp;
    logic              heat;
    logic              changed;
  } reading_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                typed;
    reading_t            want;
  } directed_row_t;

  typedef enum int {SHAPE_SPREAD, SHAPE_FLAT, SHAPE_CLUSTER} batch_shape_e;

  localparam reading_t NO_READING = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [AVG_W-1:0]     average_reading;
  logic [TEMP_W-1:0]    temperature;
  logic                 heater_on;
  logic                 heater_changed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  // predictor state
  logic [SUM_W-1:0] batch_sum;
  int               batch_fill;
  logic             heater;
  logic [THR_W-1:0] on_thr;
  logic [THR_W-1:0] off_thr;
  reading_t         readings_due[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // first batch all zeros, second all full scale, then the start of a third
  directed_row_t directed_rows [DIRECTED_LEN] = '{
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd0,    1'b1, '{10'd0, 16'd18779, 1'b0, 1'b0}},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd1023, 1'b1, '{10'd1023, 16'd32155, 1'b0, 1'b0}},
    '{10'd413,  1'b0, NO_READING},
    '{10'd1023, 1'b0, NO_READING},
    '{10'd0,    1'b0, NO_READING},
    '{10'd512,  1'b0, NO_READING},
    '{10'd1,    1'b0, NO_READING}
  };

  int phase_on  [PHASES] = '{70, 0, 255, 40, 60, PICK_RANDOM, PICK_RANDOM, 0};
  int phase_off [PHASES] = '{75, 255, 0, 60, 45, PICK_RANDOM, PICK_RANDOM, 0};

  averaged_sensor_hysteresis_thermostat_core #(
    .SAMPLE_COUNT(BATCH)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .average_reading(average_reading),
    .temperature    (temperature),
    .heater_on      (heater_on),
    .heater_changed (heater_changed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // quadratic curve in units of 2^-24 degrees, rounded to Q8.8
  function automatic logic [TEMP_W-1:0] curve_temperature(input logic [AVG_W-1:0] a);
    longint x;
    longint v;
    longint q;
    x = longint'(a);
    v = K2 * x * x - K1 * x + K0;
    if (v < 0) return '0;
    q = (v + 32768) / 65536;
    if (q > 65535) q = 65535;
    return q[TEMP_W-1:0];
  endfunction

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, output bit closed,
                               output reading_t r);
    logic [TEMP_W-1:0] t;
    closed = 1'b0;
    r = '0;
    batch_sum = batch_sum + SUM_W'(s);
    batch_fill++;
    if (batch_fill < BATCH) return;
    r.average = AVG_W'(batch_sum / BATCH);
    batch_sum = '0;
    batch_fill = 0;
    t = curve_temperature(r.average);
    r.temp = t;
    // only the rule for the current heater state is tested
    if (!heater) begin
      if (t < {on_thr, 8'h00}) begin
        heater = 1'b1;
        r.changed = 1'b1;
      end
    end else if (t > {off_thr, 8'h00}) begin
      heater = 1'b0;
      r.changed = 1'b1;
    end
    r.heat = heater;
    closed = 1'b1;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                             input reading_t want);
    bit closed;
    reading_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    absorb_sample(s, closed, r);
    if (closed) readings_due.push_back(typed ? want : r);
  endtask

  task automatic make_batch();
    int n;
    int centre;
    int v;
    batch_shape_e shape;
    n = BATCH - batch_fill;
    shape = batch_shape_e'($urandom_range(0, 2));
    centre = $urandom_range(0, SAMPLE_MAX);
    if ($urandom_range(0, 7) == 0) centre = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_SPREAD: v = $urandom_range(0, SAMPLE_MAX);
        SHAPE_FLAT: v = centre;
        default: begin
          v = centre + int'($urandom_range(0, 40)) - 20;
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end
      endcase
      push_sample(SAMPLE_W'(v), 1'b0, NO_READING);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ON_THRESHOLD) on_thr = data;
    else if (idx == REG_OFF_THRESHOLD) off_thr = data;
  endtask

  task automatic set_thresholds(input int on_deg, input int off_deg, input bit stray);
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_OFF_THRESHOLD + 1, 255)), THR_W'($urandom));
    end
    write_reg(REG_ON_THRESHOLD, THR_W'(on_deg));
    write_reg(REG_OFF_THRESHOLD, THR_W'(off_deg));
    cfg_valid <= 1'b0;
  endtask

  // hold input back until every result is out, then let the datapath settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (average %0d)",
                                  average_reading));
      end else begin
        want = readings_due.pop_front();
        if (average_reading !== want.average)
          report_mismatch($sformatf("average_reading %0d, expected %0d",
                                    average_reading, want.average));
        if (temperature !== want.temp)
          report_mismatch($sformatf("temperature %0d, expected %0d",
                                    temperature, want.temp));
        if (heater_on !== want.heat)
          report_mismatch($sformatf("heater_on %0b, expected %0b", heater_on, want.heat));
        if (heater_changed !== want.changed)
          report_mismatch($sformatf("heater_changed %0b, expected %0b",
                                    heater_changed, want.changed));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int on_deg;
    int off_deg;
    batch_sum = '0;
    batch_fill = 0;
    heater = 1'b0;
    on_thr = ON_THRESHOLD_RESET;
    off_thr = OFF_THRESHOLD_RESET;
    send_idle_pct = 37;
    recv_stall_pct = 65;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      push_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 65;
        recv_stall_pct = 37;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // phase 0 runs on the reset thresholds
      if (p > 0) begin
        on_deg = (phase_on[p] == PICK_RANDOM) ? $urandom_range(25, 130) : phase_on[p];
        off_deg = (phase_off[p] == PICK_RANDOM) ? $urandom_range(25, 130) : phase_off[p];
        drain_results();
        set_thresholds(on_deg, off_deg, p == 4);
      end
      for (int b = 0; b < BATCHES_PER_PHASE; b++) begin
        // long output hold-off while items keep coming, so the input backs up
        if (p == 2 && b == 2) hold_req = 1'b1;
        make_batch();
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ashtc_pkg.sv
rtl/ashtc_ctrl.sv
rtl/ashtc_dp.sv
rtl/averaged_sensor_hysteresis_thermostat_core.sv
tb/tb_averaged_sensor_hysteresis_thermostat_core.sv
